[sv/rkm_pkg.sv]
// ----------------------------------------------------------------------------
// rkm_pkg
// Shared types and constants for the key derivation and modexp block.
// ----------------------------------------------------------------------------
package rkm_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CFG_AW = 1;
    localparam int unsigned ACC_W  = 64;

    localparam logic [CFG_AW-1:0] CFG_PRIME_P = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_PRIME_Q = 1'b1;

    localparam logic [CFG_W-1:0] RST_PRIME_P = 16'd3;
    localparam logic [CFG_W-1:0] RST_PRIME_Q = 16'd7;

    typedef struct packed {
        logic              req_type;
        logic [WORD_W-1:0] message;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [WORD_W-1:0] modulus;
        logic [WORD_W-1:0] public_exp;
        logic [WORD_W-1:0] private_exp;
        logic              key_error;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_N,
        OP_LOAD_PHI,
        OP_E_INIT,
        OP_E_INC,
        OP_GCD_INIT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GCD_SWAP,
        OP_INV_INIT,
        OP_INV_QUOT,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_INV_UPD,
        OP_KEY_ERR,
        OP_KEY_DONE,
        OP_EXP_INIT,
        OP_RED_INIT,
        OP_RED_DONE,
        OP_EXP_MUL,
        OP_EXP_MUL_DONE,
        OP_EXP_SQR,
        OP_EXP_SQR_DONE,
        OP_EXP_SHIFT,
        OP_EXP_ZERO
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic mul_done;
        logic b_zero;
        logic gcd_one;
        logic e_ge_phi;
        logic ex_zero;
        logic ex_lsb;
        logic n_zero;
        logic key_err;
    } t_status;

endpackage

[sv/rkm_dp.sv]
// ----------------------------------------------------------------------------
// rkm_dp
// Datapath: restoring divider, shift-add modular multiplier, key and
// exponent registers.
// ----------------------------------------------------------------------------
module rkm_dp #(
    parameter int unsigned PRIME_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic [PRIME_WIDTH-1:0]         i_p,
    input  logic [PRIME_WIDTH-1:0]         i_q,
    input  logic                           i_req_type,
    input  logic [rkm_pkg::WORD_W-1:0]     i_message,
    input  rkm_pkg::t_cmd                  i_cmd,
    output rkm_pkg::t_status               o_status,
    output rkm_pkg::t_out_word             o_word
);

    localparam int unsigned W  = rkm_pkg::ACC_W;
    localparam int unsigned CW = $clog2(W + 1);
    localparam int unsigned PW = 2 * PRIME_WIDTH;

    logic [W-1:0] r_n, r_phi, r_e, r_d, r_ga, r_gb;
    logic [W-1:0] r_r0, r_r1, r_t0, r_t1;
    logic [W-1:0] r_dq, r_drem, r_dden;
    logic [CW-1:0] r_dcnt;
    logic [W-1:0] r_ma, r_mb, r_macc, r_mm;
    logic [W-1:0] r_acc, r_base, r_ex;
    logic r_err;

    logic [W-1:0] div_trial, div_shift;
    logic [W-1:0] ma_sum, ma_dbl, mul_src_a, mul_src_b;
    logic [W-1:0] sub_t;
    logic [PRIME_WIDTH-1:0] pm, qm;
    logic [PW-1:0] prod_n, prod_phi;

    assign pm = (i_p != '0) ? i_p - PRIME_WIDTH'(1) : '0;
    assign qm = (i_q != '0) ? i_q - PRIME_WIDTH'(1) : '0;

    assign prod_n   = PW'(i_p) * PW'(i_q);
    assign prod_phi = PW'(pm) * PW'(qm);

    assign div_shift = {r_drem[W-2:0], r_dq[W-1]};
    assign div_trial = div_shift - r_dden;

    always_comb begin
        if (r_macc >= r_mm - r_ma) ma_sum = r_macc - (r_mm - r_ma);
        else ma_sum = r_macc + r_ma;
        if (r_ma >= r_mm - r_ma) ma_dbl = r_ma - (r_mm - r_ma);
        else ma_dbl = r_ma + r_ma;
    end

    assign sub_t = (r_t0 >= r_macc) ? r_t0 - r_macc : r_phi - (r_macc - r_t0);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            rkm_pkg::OP_LOAD_N: begin
                r_n   <= W'(prod_n);
                r_phi <= '0;
            end
            rkm_pkg::OP_LOAD_PHI: r_phi <= W'(prod_phi);
            rkm_pkg::OP_E_INIT:   r_e <= W'(2);
            rkm_pkg::OP_E_INC:    r_e <= r_e + W'(1);
            rkm_pkg::OP_GCD_INIT: begin
                r_ga <= r_e;
                r_gb <= r_phi;
            end
            rkm_pkg::OP_DIV_INIT: begin
                r_dq   <= r_ga;
                r_dden <= r_gb;
                r_drem <= '0;
                r_dcnt <= CW'(W);
            end
            rkm_pkg::OP_DIV_STEP: begin
                if (!div_trial[W-1] || r_drem[W-1]) begin
                    r_drem <= div_trial;
                    r_dq   <= {r_dq[W-2:0], 1'b1};
                end else begin
                    r_drem <= div_shift;
                    r_dq   <= {r_dq[W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt - CW'(1);
            end
            rkm_pkg::OP_GCD_SWAP: begin
                r_ga <= r_gb;
                r_gb <= r_drem;
            end
            rkm_pkg::OP_INV_INIT: begin
                r_r0 <= r_phi;
                r_r1 <= r_e;
                r_t0 <= '0;
                r_t1 <= W'(1);
                r_ga <= r_phi;
                r_gb <= r_e;
            end
            rkm_pkg::OP_INV_QUOT: begin
                r_ga <= r_dq;
                r_gb <= r_drem;
            end
            rkm_pkg::OP_MUL_INIT: begin
                r_ma   <= mul_src_a;
                r_mb   <= mul_src_b;
                r_macc <= '0;
                r_mm   <= r_phi;
            end
            rkm_pkg::OP_MUL_STEP: begin
                if (r_mb[0]) r_macc <= ma_sum;
                r_ma <= ma_dbl;
                r_mb <= r_mb >> 1;
            end
            rkm_pkg::OP_INV_UPD: begin
                r_r0 <= r_r1;
                r_r1 <= r_gb;
                r_t0 <= r_t1;
                r_t1 <= sub_t;
                r_ga <= r_r1;
                r_gb <= r_gb;
            end
            rkm_pkg::OP_KEY_ERR: begin
                r_err <= 1'b1;
                r_d   <= r_phi;
            end
            rkm_pkg::OP_KEY_DONE: begin
                r_err <= 1'b0;
                r_d   <= r_t0;
            end
            rkm_pkg::OP_EXP_INIT: begin
                r_ex  <= i_req_type ? r_d : r_e;
                r_ga  <= W'(i_message);
                r_gb  <= r_n;
            end
            rkm_pkg::OP_RED_INIT: begin
                r_dq   <= r_ga;
                r_dden <= r_gb;
                r_drem <= '0;
                r_dcnt <= CW'(W);
                r_mm   <= r_n;
            end
            rkm_pkg::OP_RED_DONE: begin
                r_base <= r_drem;
                r_acc  <= (r_n == W'(1)) ? '0 : W'(1);
            end
            rkm_pkg::OP_EXP_MUL: begin
                r_ma <= r_acc; r_mb <= r_base; r_macc <= '0;
            end
            rkm_pkg::OP_EXP_MUL_DONE: r_acc <= r_macc;
            rkm_pkg::OP_EXP_SQR: begin
                r_ma <= r_base; r_mb <= r_base; r_macc <= '0;
            end
            rkm_pkg::OP_EXP_SQR_DONE: r_base <= r_macc;
            rkm_pkg::OP_EXP_SHIFT:    r_ex <= r_ex >> 1;
            rkm_pkg::OP_EXP_ZERO:     r_acc <= '0;
            default: ;
        endcase
    end

    // inverse update: qt % phi times t1 mod phi (qt < phi holds here)
    assign mul_src_a = r_ga;
    assign mul_src_b = r_t1;

    always_comb begin
        o_status.div_done = (r_dcnt == '0);
        o_status.mul_done = (r_mb == '0);
        o_status.b_zero   = (r_gb == '0);
        o_status.gcd_one  = (r_ga == W'(1));
        o_status.e_ge_phi = (r_e >= r_phi);
        o_status.ex_zero  = (r_ex == '0);
        o_status.ex_lsb   = r_ex[0];
        o_status.n_zero   = (r_n == '0);
        o_status.key_err  = r_err;
    end

    assign o_word.result      = r_acc[rkm_pkg::WORD_W-1:0];
    assign o_word.modulus     = r_n[rkm_pkg::WORD_W-1:0];
    assign o_word.public_exp  = r_e[rkm_pkg::WORD_W-1:0];
    assign o_word.private_exp = r_d[rkm_pkg::WORD_W-1:0];
    assign o_word.key_error   = r_err;

endmodule

[sv/rkm_ctrl.sv]
// ----------------------------------------------------------------------------
// rkm_ctrl
// Controller: key search, extended Euclid, square-and-multiply sequencing.
// ----------------------------------------------------------------------------
module rkm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_keys_valid,
    input  rkm_pkg::t_status i_status,
    output rkm_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_keys_set,
    output logic             o_done,
    output logic             o_zero_res
);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD_N, S_LOAD_PHI, S_E_INIT, S_CHK_E, S_GCD_DIV0, S_GCD_DIV,
        S_GCD_SWAP, S_GCD_TEST, S_INV_INIT, S_INV_TEST, S_INV_DIV0, S_INV_DIV,
        S_INV_QUOT, S_INV_MUL0, S_INV_MUL, S_INV_UPD, S_KEY_DONE, S_KEY_ERR,
        S_EXP_INIT, S_RED0, S_RED, S_RED_DONE, S_EXP_TEST, S_MUL, S_MUL_DONE,
        S_SQR, S_SQR_DONE, S_SHIFT, S_FIN
    } t_state;

    t_state r_state, n_state;
    rkm_pkg::t_op n_op;
    logic r_busy, r_done, r_zero;

    always_comb begin
        n_state = r_state;
        n_op    = rkm_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                if (i_keys_valid) begin
                    n_state = S_EXP_INIT;
                end else begin
                    n_state = S_LOAD_N; n_op = rkm_pkg::OP_LOAD_N;
                end
            end
            S_LOAD_N:  begin n_state = S_LOAD_PHI; n_op = rkm_pkg::OP_LOAD_PHI; end
            S_LOAD_PHI: begin n_state = S_E_INIT; n_op = rkm_pkg::OP_E_INIT; end
            S_E_INIT:  n_state = S_CHK_E;
            S_CHK_E: if (i_status.e_ge_phi) begin
                n_state = S_KEY_ERR; n_op = rkm_pkg::OP_KEY_ERR;
            end else begin
                n_state = S_GCD_DIV0; n_op = rkm_pkg::OP_GCD_INIT;
            end
            S_GCD_DIV0: if (i_status.b_zero) begin
                n_state = S_GCD_TEST;
            end else begin
                n_state = S_GCD_DIV; n_op = rkm_pkg::OP_DIV_INIT;
            end
            S_GCD_DIV: if (i_status.div_done) begin
                n_state = S_GCD_SWAP; n_op = rkm_pkg::OP_GCD_SWAP;
            end else n_op = rkm_pkg::OP_DIV_STEP;
            S_GCD_SWAP: n_state = S_GCD_DIV0;
            S_GCD_TEST: if (i_status.gcd_one) begin
                n_state = S_INV_INIT; n_op = rkm_pkg::OP_INV_INIT;
            end else begin
                n_state = S_E_INIT; n_op = rkm_pkg::OP_E_INC;
            end
            S_INV_INIT: n_state = S_INV_TEST;
            S_INV_TEST: if (i_status.b_zero) begin
                n_state = S_KEY_DONE; n_op = rkm_pkg::OP_KEY_DONE;
            end else begin
                n_state = S_INV_DIV; n_op = rkm_pkg::OP_DIV_INIT;
            end
            S_INV_DIV0: n_state = S_INV_DIV;
            S_INV_DIV: if (i_status.div_done) begin
                n_state = S_INV_QUOT; n_op = rkm_pkg::OP_INV_QUOT;
            end else n_op = rkm_pkg::OP_DIV_STEP;
            S_INV_QUOT: begin n_state = S_INV_MUL; n_op = rkm_pkg::OP_MUL_INIT; end
            S_INV_MUL0: n_state = S_INV_MUL;
            S_INV_MUL: if (i_status.mul_done) begin
                n_state = S_INV_UPD; n_op = rkm_pkg::OP_INV_UPD;
            end else n_op = rkm_pkg::OP_MUL_STEP;
            S_INV_UPD:  n_state = S_INV_TEST;
            S_MUL_DONE: begin n_state = S_SQR; n_op = rkm_pkg::OP_EXP_SQR; end
            S_KEY_DONE, S_KEY_ERR: n_state = S_EXP_INIT;
            S_EXP_INIT: begin n_state = S_RED0; n_op = rkm_pkg::OP_EXP_INIT; end
            S_RED0: begin n_state = S_RED; n_op = rkm_pkg::OP_RED_INIT; end
            S_RED: if (i_status.key_err || i_status.n_zero) begin
                n_state = S_FIN; n_op = rkm_pkg::OP_EXP_ZERO;
            end else if (i_status.div_done) begin
                n_state = S_RED_DONE; n_op = rkm_pkg::OP_RED_DONE;
            end else n_op = rkm_pkg::OP_DIV_STEP;
            S_RED_DONE: n_state = S_EXP_TEST;
            S_EXP_TEST: if (i_status.ex_zero) begin
                n_state = S_FIN;
            end else if (i_status.ex_lsb) begin
                n_state = S_MUL; n_op = rkm_pkg::OP_EXP_MUL;
            end else begin
                n_state = S_SQR; n_op = rkm_pkg::OP_EXP_SQR;
            end
            S_MUL: if (i_status.mul_done) begin
                n_state = S_MUL_DONE; n_op = rkm_pkg::OP_EXP_MUL_DONE;
            end else n_op = rkm_pkg::OP_MUL_STEP;
            S_SQR: if (i_status.mul_done) begin
                n_state = S_SQR_DONE; n_op = rkm_pkg::OP_EXP_SQR_DONE;
            end else n_op = rkm_pkg::OP_MUL_STEP;
            S_SQR_DONE: begin n_state = S_SHIFT; n_op = rkm_pkg::OP_EXP_SHIFT; end
            S_SHIFT: n_state = S_EXP_TEST;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_zero    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state != S_IDLE);
            r_done   <= (r_state == S_FIN);
            r_zero   <= (n_op == rkm_pkg::OP_EXP_ZERO) ? 1'b1 :
                        ((r_state == S_IDLE) ? 1'b0 : r_zero);
        end
    end

    assign o_cmd.op   = n_op;
    assign o_busy     = r_busy || (r_state != S_IDLE);
    assign o_keys_set = (r_state == S_KEY_DONE) || (r_state == S_KEY_ERR);
    assign o_done     = r_done;
    assign o_zero_res = r_zero;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_FIN)) else $error("done without finish");
    a_keys_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_keys_set |-> !i_keys_valid) else $error("keys set twice");
    a_idle_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |-> o_cmd.op == rkm_pkg::OP_NONE)
        else $error("command while idle");

endmodule

[sv/rsa_keygen_and_modexp_top.sv]
// ----------------------------------------------------------------------------
// rsa_keygen_and_modexp_top
// Key derivation from two primes and modular exponentiation per request.
//
//   channel | direction | handshake            | word
//   in      | input     | i_valid / o_stall    | t_in_word
//   out     | output    | o_valid / i_stall    | t_out_word
//   cfg     | input     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One word at a time. Each modular multiply is a bit-serial shift-add over
// operands below 2^32; a request squares once per exponent bit, multiplies
// too where the bit is set, and first reduces the message modulo n. The
// first request after reset or a config write also runs the e search (one
// division per gcd step) and extended Euclid. Reset is synchronous; stall
// on the output holds the result register and the block takes no new word
// until it drains.
// ----------------------------------------------------------------------------
module rsa_keygen_and_modexp_top #(
    parameter int unsigned PRIME_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  rkm_pkg::t_in_word           i_word,
    output logic                        o_valid,
    input  logic                        i_stall,
    output rkm_pkg::t_out_word          o_word,
    input  logic                        i_cfg_we,
    input  logic [rkm_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [rkm_pkg::CFG_W-1:0]   i_cfg_data
);

    logic [PRIME_WIDTH-1:0] r_p, r_q;
    logic r_keys_valid, r_out_valid, r_req_type;
    logic [rkm_pkg::WORD_W-1:0] r_message;
    rkm_pkg::t_out_word r_out, dp_word;
    rkm_pkg::t_cmd cmd;
    rkm_pkg::t_status status;
    logic busy, keys_set, done, zero_res, in_acc;

    assign o_stall = busy || r_out_valid || done;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p          <= PRIME_WIDTH'(rkm_pkg::RST_PRIME_P);
            r_q          <= PRIME_WIDTH'(rkm_pkg::RST_PRIME_Q);
            r_keys_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rkm_pkg::CFG_PRIME_P: r_p <= PRIME_WIDTH'(i_cfg_data);
                    rkm_pkg::CFG_PRIME_Q: r_q <= PRIME_WIDTH'(i_cfg_data);
                    default: ;
                endcase
                r_keys_valid <= 1'b0;
            end else if (keys_set) begin
                r_keys_valid <= 1'b1;
            end
            if (done) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
        if (in_acc) begin
            r_req_type <= i_word.req_type;
            r_message  <= i_word.message;
        end
        if (done) begin
            r_out.result      <= zero_res ? '0 : dp_word.result;
            r_out.modulus     <= dp_word.modulus;
            r_out.public_exp  <= dp_word.public_exp;
            r_out.private_exp <= dp_word.private_exp;
            r_out.key_error   <= dp_word.key_error;
        end
    end

    rkm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(in_acc),
        .i_keys_valid(r_keys_valid), .i_status(status), .o_cmd(cmd),
        .o_busy(busy), .o_keys_set(keys_set), .o_done(done), .o_zero_res(zero_res)
    );

    rkm_dp #(.PRIME_WIDTH(PRIME_WIDTH)) u_dp (
        .i_clk(i_clk), .i_p(r_p), .i_q(r_q), .i_req_type(r_req_type),
        .i_message(r_message), .i_cmd(cmd), .o_status(status), .o_word(dp_word)
    );

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

[dv/rsa_keygen_and_modexp_top_test.sv]
// ----------------------------------------------------------------------------
// rsa_keygen_and_modexp_top_test
// Self-checking bench for the key derivation and modexp block. Each accepted
// request word is run through a local key derivation and square-and-multiply
// predictor. Each output word is compared field by field against the oldest
// prediction. The run sweeps the factor registers over reset, degenerate,
// extreme and random settings, with random gaps on the input and random
// stalls on the output.
// ----------------------------------------------------------------------------
module rsa_keygen_and_modexp_top_test;

    localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_valid    = 1'b0;
    logic                          o_stall;
    rkm_pkg::t_in_word             i_word     = '0;
    logic                          o_valid;
    logic                          i_stall    = 1'b0;
    rkm_pkg::t_out_word            o_word;
    logic                          i_cfg_we   = 1'b0;
    logic [rkm_pkg::CFG_AW-1:0]    i_cfg_idx  = rkm_pkg::CFG_PRIME_P;
    logic [rkm_pkg::CFG_W-1:0]     i_cfg_data = '0;

    rsa_keygen_and_modexp_top #(.PRIME_WIDTH(16)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    longint unsigned     factor_p = 64'(rkm_pkg::RST_PRIME_P);
    longint unsigned     factor_q = 64'(rkm_pkg::RST_PRIME_Q);
    bit                  key_ready = 1'b0;
    longint unsigned     key_n, key_e, key_d;
    bit                  key_err;
    rkm_pkg::t_out_word  pending_words[$];
    int                  mismatches = 0;
    longint unsigned     cycle_count = 0;
    bit                  calm = 1'b0;

    int unsigned small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                                    53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107,
                                    109, 113, 127, 131, 137, 139, 149, 151, 157, 163, 167,
                                    173, 179, 181, 191, 193, 197, 199, 211, 223, 227, 229,
                                    233, 239, 241, 251};

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint unsigned inverse_of(longint unsigned e, longint unsigned phi);
        longint r0, r1, t0, t1, qt, tmp;
        r0 = phi; r1 = e; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            qt  = r0 / r1;
            tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
            tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
        end
        t0 = t0 % longint'(phi);
        if (t0 < 0) t0 += phi;
        return t0;
    endfunction

    function automatic longint unsigned modexp(longint unsigned base, longint unsigned ex,
                                               longint unsigned m);
        longint unsigned acc;
        acc  = 1 % m;
        base = base % m;
        while (ex != 0) begin
            if (ex[0]) acc = (acc * base) % m;
            base = (base * base) % m;
            ex >>= 1;
        end
        return acc;
    endfunction

    task automatic derive_rsa_keys();
        longint unsigned pm, qm, phi, e;
        pm    = (factor_p > 0) ? factor_p - 1 : 0;
        qm    = (factor_q > 0) ? factor_q - 1 : 0;
        phi   = pm * qm;
        key_n = factor_p * factor_q;
        e     = 2;
        while (e < phi && gcd_of(e, phi) != 1) e++;
        if (e >= phi) begin
            key_err = 1'b1;
            key_d   = phi;
        end else begin
            key_err = 1'b0;
            key_d   = inverse_of(e, phi);
        end
        key_e     = e;
        key_ready = 1'b1;
    endtask

    task automatic predict_word(rkm_pkg::t_in_word w);
        rkm_pkg::t_out_word x;
        longint unsigned    res;
        if (!key_ready) derive_rsa_keys();
        res = 0;
        if (!key_err && key_n != 0)
            res = modexp(64'(w.message), w.req_type ? key_d : key_e, key_n);
        x.result      = res[31:0];
        x.modulus     = key_n[31:0];
        x.public_exp  = key_e[31:0];
        x.private_exp = key_d[31:0];
        x.key_error   = key_err;
        pending_words.push_back(x);
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h expected %0h (p=%0d q=%0d)",
                 what, got, want, factor_p, factor_q);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rsa_keygen_and_modexp_top_test: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_word.result), 64'd0);
            end else begin
                rkm_pkg::t_out_word want;
                want = pending_words.pop_front();
                if (o_word.result !== want.result)
                    report_mismatch("result", 64'(o_word.result), 64'(want.result));
                if (o_word.modulus !== want.modulus)
                    report_mismatch("modulus", 64'(o_word.modulus), 64'(want.modulus));
                if (o_word.public_exp !== want.public_exp)
                    report_mismatch("public_exp", 64'(o_word.public_exp),
                                    64'(want.public_exp));
                if (o_word.private_exp !== want.private_exp)
                    report_mismatch("private_exp", 64'(o_word.private_exp),
                                    64'(want.private_exp));
                if (o_word.key_error !== want.key_error)
                    report_mismatch("key_error", 64'(o_word.key_error),
                                    64'(want.key_error));
            end
        end
    end

    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = calm ? 0 : $urandom_range(0, 6);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_word(bit rt, logic [31:0] msg);
        int                gap;
        rkm_pkg::t_in_word w;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.req_type = rt;
        w.message  = msg;
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        predict_word(w);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rkm_pkg::CFG_AW-1:0] idx, logic [15:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rkm_pkg::CFG_PRIME_P) factor_p = 64'(val);
        else factor_q = 64'(val);
        key_ready = 1'b0;
    endtask

    task automatic set_factors(logic [15:0] p, logic [15:0] q);
        write_reg(rkm_pkg::CFG_PRIME_P, p);
        write_reg(rkm_pkg::CFG_PRIME_Q, q);
    endtask

    task automatic send_edges();
        send_word(1'b0, 32'd0);
        send_word(1'b1, 32'd0);
        send_word(1'b0, 32'hFFFF_FFFF);
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b0, 32'(factor_p * factor_q));
        send_word(1'b1, 32'(factor_p * factor_q - 1));
    endtask

    task automatic test_reset_keys();
        send_edges();
        send_word(1'b0, 32'd5);
        send_word(1'b1, 32'd17);
    endtask

    task automatic test_degenerate_factors();
        set_factors(16'd0, 16'd5);
        send_word(1'b0, 32'd4);
        write_reg(rkm_pkg::CFG_PRIME_P, 16'd1);
        send_word(1'b1, 32'd9);
        set_factors(16'd2, 16'd2);
        send_word(1'b0, 32'd3);
        set_factors(16'd2, 16'd3);
        send_word(1'b1, 32'd5);
        set_factors(16'd3, 16'd2);
        send_word(1'b0, 32'd5);
    endtask

    task automatic test_wide_factors();
        set_factors(16'hFFFF, 16'hFFFF);
        send_edges();
        set_factors(16'd65521, 16'd65519);
        send_word(1'b0, $urandom);
        send_word(1'b1, $urandom);
    endtask

    task automatic test_random_traffic();
        int k, items, sel;
        logic [15:0] p, q;
        for (k = 0; k < 20; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                p = 16'(small_primes[$urandom_range(0, small_primes.size() - 1)]);
                q = 16'(small_primes[$urandom_range(0, small_primes.size() - 1)]);
            end else if (sel < 9) begin
                p = 16'($urandom);
                q = 16'($urandom);
            end else begin
                p = 16'($urandom_range(0, 3));
                q = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 3) == 0) write_reg(rkm_pkg::CFG_PRIME_Q, q);
            else set_factors(p, q);
            calm  = ($urandom_range(0, 4) == 0);
            items = (sel >= 7 && sel < 9) ? 20 : 110;
            repeat (items) begin
                if ($urandom_range(0, 7) == 0)
                    send_word(1'($urandom_range(0, 1)), 32'(factor_p * factor_q)
                              - $urandom_range(0, 1));
                else
                    send_word(1'($urandom_range(0, 1)), $urandom);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_keys();
        test_degenerate_factors();
        test_wide_factors();
        test_random_traffic();
        drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("rsa_keygen_and_modexp_top_test: PASS");
        else
            $display("rsa_keygen_and_modexp_top_test: FAIL");
        $finish;
    end

endmodule

[files.f]
sv/rkm_pkg.sv
sv/rkm_dp.sv
sv/rkm_ctrl.sv
sv/rsa_keygen_and_modexp_top.sv
dv/rsa_keygen_and_modexp_top_test.sv
